### hdl/sbs_pkg.sv
package sbs_pkg;

  // Fixed-point format: signed, FRAC_BITS fractional bits.
  localparam int FRAC_BITS = 16;
  localparam logic [30:0] ONE_Q = 31'(1) << FRAC_BITS;

  // The unit vectors of pursuit have components in [-1.0, 1.0].
  localparam int UNIT_W = FRAC_BITS + 2;
  localparam int DOT_W  = 2 * FRAC_BITS + 3;

  typedef logic signed [31:0] s32_t;
  typedef logic signed [65:0] wide_t;

  localparam wide_t S32_MAX_W = 66'sh7FFFFFFF;
  localparam wide_t S32_MIN_W = -66'sh80000000;

  // Configuration register indexes.
  localparam logic [2:0] CFG_MODE             = 3'd0;
  localparam logic [2:0] CFG_MAX_SPEED        = 3'd1;
  localparam logic [2:0] CFG_MAX_FORCE        = 3'd2;
  localparam logic [2:0] CFG_MASS             = 3'd3;
  localparam logic [2:0] CFG_SLOWING_DISTANCE = 3'd4;

  // Behaviour codes held in the mode register.
  localparam logic [2:0] MODE_SEEK    = 3'd0;
  localparam logic [2:0] MODE_FLEE    = 3'd1;
  localparam logic [2:0] MODE_PURSUIT = 3'd2;
  localparam logic [2:0] MODE_EVADE   = 3'd3;
  localparam logic [2:0] MODE_ARRIVAL = 3'd4;

  localparam logic [30:0] MAX_SPEED_RST        = 31'(10) << FRAC_BITS;
  localparam logic [30:0] MAX_FORCE_RST        = 31'(1) << FRAC_BITS;
  localparam logic [30:0] MASS_RST             = 31'(1) << FRAC_BITS;
  localparam logic [30:0] SLOWING_DISTANCE_RST = 31'(100) << FRAC_BITS;

  // Status of an iterative arithmetic unit.
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  function automatic s32_t sat32(wide_t x);
    s32_t r;
    if (x > S32_MAX_W) begin
      r = 32'sh7FFFFFFF;
    end else if (x < S32_MIN_W) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  // Signed division by 2^FRAC_BITS, truncated toward zero.
  function automatic wide_t sdiv_pow2(wide_t x);
    wide_t bias;
    bias = x[65] ? ((wide_t'(1) <<< FRAC_BITS) - wide_t'(1)) : wide_t'(0);
    return (x + bias) >>> FRAC_BITS;
  endfunction

  function automatic logic [63:0] mag64(wide_t x);
    wide_t a;
    a = x[65] ? -x : x;
    return a[63:0];
  endfunction

  function automatic s32_t sat_diff(s32_t a, s32_t b);
    return sat32(wide_t'(a) - wide_t'(b));
  endfunction

endpackage

### hdl/sbs_if.sv
interface sbs_target_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] target_pos_x;
  logic signed [31:0] target_pos_y;
  logic signed [31:0] target_pos_z;
  logic signed [31:0] target_vel_x;
  logic signed [31:0] target_vel_y;
  logic signed [31:0] target_vel_z;
  logic signed [31:0] own_pos_x;
  logic signed [31:0] own_pos_y;
  logic signed [31:0] own_pos_z;

  modport source (
    output valid, target_pos_x, target_pos_y, target_pos_z,
           target_vel_x, target_vel_y, target_vel_z, own_pos_x, own_pos_y, own_pos_z,
    input  ready
  );
  modport sink (
    input  valid, target_pos_x, target_pos_y, target_pos_z,
           target_vel_x, target_vel_y, target_vel_z, own_pos_x, own_pos_y, own_pos_z,
    output ready
  );
endinterface

interface sbs_result_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] new_vel_x;
  logic signed [31:0] new_vel_y;
  logic signed [31:0] new_vel_z;
  logic signed [31:0] new_pos_x;
  logic signed [31:0] new_pos_y;
  logic signed [31:0] new_pos_z;

  modport source (
    output valid, new_vel_x, new_vel_y, new_vel_z, new_pos_x, new_pos_y, new_pos_z,
    input  ready
  );
  modport sink (
    input  valid, new_vel_x, new_vel_y, new_vel_z, new_pos_x, new_pos_y, new_pos_z,
    output ready
  );
endinterface

### hdl/sbs_div.sv
// Unsigned 64 by 32 restoring divider, one quotient bit per cycle.
module sbs_div (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [63:0]         num,
  input  logic [31:0]         den,
  output logic [63:0]         quo,
  output sbs_pkg::unit_stat_t stat
);

  logic [31:0] rem;
  logic [31:0] dvs;
  logic [5:0]  cnt;
  logic [32:0] rem_sh;
  logic        fits;

  assign rem_sh = {rem, quo[63]};
  assign fits   = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    stat.done <= 1'b0;
    if (rst) begin
      stat.busy <= 1'b0;
    end else if (start) begin
      stat.busy <= 1'b1;
      rem       <= '0;
      dvs       <= den;
      quo       <= num;
      cnt       <= '0;
    end else if (stat.busy) begin
      rem <= fits ? 32'(rem_sh - {1'b0, dvs}) : rem_sh[31:0];
      quo <= {quo[62:0], fits};
      cnt <= cnt + 6'd1;
      if (cnt == 6'd63) begin
        stat.busy <= 1'b0;
        stat.done <= 1'b1;
      end
    end
  end

endmodule

### hdl/sbs_sqrt.sv
// Integer square root of a 64-bit value, two radicand bits per cycle.
module sbs_sqrt (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [63:0]         rad,
  output logic [31:0]         root,
  output sbs_pkg::unit_stat_t stat
);

  logic [63:0] x;
  logic [63:0] res;
  logic [63:0] bitv;
  logic [4:0]  cnt;
  logic [63:0] trial;

  assign trial = res + bitv;
  assign root  = res[31:0];

  always_ff @(posedge clk) begin
    stat.done <= 1'b0;
    if (rst) begin
      stat.busy <= 1'b0;
    end else if (start) begin
      stat.busy <= 1'b1;
      x         <= rad;
      res       <= '0;
      bitv      <= 64'(1) << 62;
      cnt       <= '0;
    end else if (stat.busy) begin
      if (x >= trial) begin
        x   <= x - trial;
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      bitv <= bitv >> 2;
      cnt  <= cnt + 5'd1;
      if (cnt == 5'd31) begin
        stat.busy <= 1'b0;
        stat.done <= 1'b1;
      end
    end
  end

endmodule

### hdl/steering_behaviour_step_unit.sv
// Steering step for one agent in signed Q16.16. Each word on the target port carries the
// target's position and velocity and the agent's own position; the block forms a seek, flee,
// pursuit, evade or arrival force, limits it to max_force, divides it by mass, adds it to the
// velocity it keeps, limits that velocity to max_speed and returns the new velocity and the
// new position as one word on the result port. One word is worked on at a time, and the
// target port is not ready meanwhile. The time an item takes is set by the shared divider,
// which yields one quotient bit a cycle, and by the shared square-root unit. Arrival adds
// one division to the work of seek and flee. Each limit that bites, on the force or on the
// speed, adds a scaling. Pursuit and evade take the longest, with as many as 19 divisions
// in the item. A finished word is held in the output register while the next target word
// is taken; the step only waits longer if that register still holds an unaccepted word
// when the next one is done.
module steering_behaviour_step_unit (
  input  logic        clk,
  input  logic        rst,
  sbs_target_if.sink  target,
  sbs_result_if.source result,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [30:0] cfg_data
);

  typedef enum logic [5:0] {
    S_IDLE, S_DISPATCH,
    S_LEN, S_LEN_MUL, S_LEN_ACC, S_LEN_WAIT,
    S_SCALE, S_SC_MUL, S_SC_DIV, S_SC_WAIT,
    S_SEEK_SC,
    S_ARR_MUL, S_ARR_DIV, S_ARR_WAIT,
    S_P_UA, S_P_AWAY, S_P_UB, S_P_DOT0, S_P_DOTM, S_P_DOTA, S_P_PARA,
    S_P_SPEED, S_P_TU, S_P_TUW, S_P_TM, S_P_TT,
    S_P_PT0, S_P_PTM, S_P_PTA, S_P_SEEK,
    S_FORCE, S_FCLAMP, S_ACC, S_ACC_DIV, S_ACC_WAIT, S_VCLAMP, S_DONE
  } state_t;

  state_t state;
  state_t ret;

  // Configuration registers.
  logic [2:0]  mode;
  logic [30:0] max_speed;
  logic [30:0] max_force;
  logic [30:0] mass;
  logic [30:0] slowing_distance;

  // Captured word and the kept agent velocity.
  sbs_pkg::s32_t tp [3];
  sbs_pkg::s32_t tv [3];
  sbs_pkg::s32_t own [3];
  sbs_pkg::s32_t vel [3];

  // Working vectors: vw is the operand of the length and scaling routines, vs the scaling result.
  sbs_pkg::s32_t vw [3];
  sbs_pkg::s32_t vs [3];
  logic signed [sbs_pkg::UNIT_W-1:0] ua [3];

  logic [1:0]   idx;
  logic [63:0]  sq_acc;
  logic [31:0]  len_q;
  logic [30:0]  mag;
  logic [31:0]  dist_len;
  logic [30:0]  tu;
  logic signed [sbs_pkg::DOT_W-1:0]  dot;
  logic signed [sbs_pkg::UNIT_W-1:0] para;
  sbs_pkg::s32_t t;
  logic          div_neg;

  // Output register.
  logic          out_valid;
  sbs_pkg::s32_t out_vel [3];
  sbs_pkg::s32_t out_pos [3];

  // Shared multiplier, registered.
  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  sbs_pkg::wide_t     mul_p;

  // Shared divider and square root.
  logic                div_start;
  logic [63:0]         div_num;
  logic [31:0]         div_den;
  logic                div_neg_c;
  logic [63:0]         div_quo;
  sbs_pkg::unit_stat_t div_stat;
  sbs_pkg::wide_t      q_s;

  logic                sqrt_start;
  logic [63:0]         sqrt_rad;
  logic [31:0]         sqrt_root;
  sbs_pkg::unit_stat_t sqrt_stat;

  sbs_pkg::wide_t dq;

  sbs_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .quo  (div_quo),
    .stat (div_stat)
  );

  sbs_sqrt u_sqrt (
    .clk  (clk),
    .rst  (rst),
    .start(sqrt_start),
    .rad  (sqrt_rad),
    .root (sqrt_root),
    .stat (sqrt_stat)
  );

  // Signed quotient: the divider works on magnitudes and the sign is put back here.
  assign q_s = div_neg ? -sbs_pkg::wide_t'({2'b00, div_quo})
                       : sbs_pkg::wide_t'({2'b00, div_quo});

  assign dq = sbs_pkg::sdiv_pow2(sbs_pkg::wide_t'(dot));

  assign sqrt_start = (state == S_LEN_ACC) && (idx == 2'd2);
  assign sqrt_rad   = sq_acc + mul_p[63:0];

  // Operand selection for the shared units.
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    div_neg_c = 1'b0;
    case (state)
      S_LEN_MUL: begin
        mul_a = 33'(vw[idx]);
        mul_b = 33'(vw[idx]);
      end
      S_SC_MUL: begin
        mul_a = 33'(vw[idx]);
        mul_b = signed'({2'b00, mag});
      end
      S_ARR_MUL: begin
        mul_a = signed'({2'b00, max_speed});
        mul_b = signed'({1'b0, len_q});
      end
      S_P_DOTM: begin
        mul_a = 33'(ua[idx]);
        mul_b = 33'(vs[idx]);
      end
      S_P_TM: begin
        mul_a = signed'({2'b00, tu});
        mul_b = 33'(para);
      end
      S_P_PTM: begin
        mul_a = 33'(tv[idx]);
        mul_b = 33'(t);
      end
      S_SC_DIV: begin
        div_start = 1'b1;
        div_num   = sbs_pkg::mag64(mul_p);
        div_den   = len_q;
        div_neg_c = mul_p[65];
      end
      S_ARR_DIV: begin
        div_start = 1'b1;
        div_num   = mul_p[63:0];
        div_den   = {1'b0, slowing_distance};
      end
      S_P_TU: begin
        div_start = (len_q != '0);
        div_num   = 64'(dist_len) << sbs_pkg::FRAC_BITS;
        div_den   = len_q;
      end
      S_ACC_DIV: begin
        div_start = 1'b1;
        div_num   = sbs_pkg::mag64(sbs_pkg::wide_t'(vs[idx])) << sbs_pkg::FRAC_BITS;
        div_den   = {1'b0, mass};
        div_neg_c = vs[idx][31];
      end
      default: begin
      end
    endcase
  end

  assign target.ready = (state == S_IDLE);

  assign result.valid     = out_valid;
  assign result.new_vel_x = out_vel[0];
  assign result.new_vel_y = out_vel[1];
  assign result.new_vel_z = out_vel[2];
  assign result.new_pos_x = out_pos[0];
  assign result.new_pos_y = out_pos[1];
  assign result.new_pos_z = out_pos[2];

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode             <= sbs_pkg::MODE_SEEK;
      max_speed        <= sbs_pkg::MAX_SPEED_RST;
      max_force        <= sbs_pkg::MAX_FORCE_RST;
      mass             <= sbs_pkg::MASS_RST;
      slowing_distance <= sbs_pkg::SLOWING_DISTANCE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        sbs_pkg::CFG_MODE:             mode             <= cfg_data[2:0];
        sbs_pkg::CFG_MAX_SPEED:        max_speed        <= cfg_data;
        sbs_pkg::CFG_MAX_FORCE:        max_force        <= cfg_data;
        sbs_pkg::CFG_MASS:             mass             <= cfg_data;
        sbs_pkg::CFG_SLOWING_DISTANCE: slowing_distance <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    mul_p <= sbs_pkg::wide_t'(mul_a) * sbs_pkg::wide_t'(mul_b);
    if (div_start) begin
      div_neg <= div_neg_c;
    end
  end

  // Sequencer. LEN (length of vw into len_q) and SCALE (vw scaled to mag over len_q into vs)
  // are shared routines; the caller sets ret to the state that follows.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ret       <= S_IDLE;
      out_valid <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        vel[i] <= '0;
      end
    end else begin
      // The output register is loaded as a step completes and emptied when taken.
      if ((state == S_DONE) && (!out_valid || result.ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (target.valid) begin
            tp[0]  <= target.target_pos_x;
            tp[1]  <= target.target_pos_y;
            tp[2]  <= target.target_pos_z;
            tv[0]  <= target.target_vel_x;
            tv[1]  <= target.target_vel_y;
            tv[2]  <= target.target_vel_z;
            own[0] <= target.own_pos_x;
            own[1] <= target.own_pos_y;
            own[2] <= target.own_pos_z;
            state  <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          state <= S_LEN;
          case (mode)
            sbs_pkg::MODE_SEEK: begin
              for (int i = 0; i < 3; i++) begin
                vw[i] <= sbs_pkg::sat_diff(tp[i], own[i]);
              end
              mag <= max_speed;
              ret <= S_SEEK_SC;
            end
            sbs_pkg::MODE_PURSUIT, sbs_pkg::MODE_EVADE: begin
              for (int i = 0; i < 3; i++) begin
                vw[i] <= tv[i];
              end
              mag <= sbs_pkg::ONE_Q;
              ret <= S_P_UA;
            end
            sbs_pkg::MODE_ARRIVAL: begin
              for (int i = 0; i < 3; i++) begin
                vw[i] <= sbs_pkg::sat_diff(tp[i], own[i]);
              end
              ret <= S_ARR_MUL;
            end
            default: begin
              // Flee, and the unused codes that behave as flee.
              for (int i = 0; i < 3; i++) begin
                vw[i] <= sbs_pkg::sat_diff(own[i], tp[i]);
              end
              mag <= max_speed;
              ret <= S_SEEK_SC;
            end
          endcase
        end

        // Length of vw: three squares summed, then the square root.
        S_LEN: begin
          sq_acc <= '0;
          idx    <= '0;
          state  <= S_LEN_MUL;
        end
        S_LEN_MUL: begin
          state <= S_LEN_ACC;
        end
        S_LEN_ACC: begin
          sq_acc <= sqrt_rad;
          if (idx == 2'd2) begin
            state <= S_LEN_WAIT;
          end else begin
            idx   <= idx + 2'd1;
            state <= S_LEN_MUL;
          end
        end
        S_LEN_WAIT: begin
          if (sqrt_stat.done) begin
            len_q <= sqrt_root;
            state <= ret;
          end
        end

        // vw scaled to magnitude mag; a zero length gives the zero vector.
        S_SCALE: begin
          idx <= '0;
          if (len_q == '0) begin
            for (int i = 0; i < 3; i++) begin
              vs[i] <= '0;
            end
            state <= ret;
          end else begin
            state <= S_SC_MUL;
          end
        end
        S_SC_MUL: begin
          state <= S_SC_DIV;
        end
        S_SC_DIV: begin
          state <= S_SC_WAIT;
        end
        S_SC_WAIT: begin
          if (div_stat.done) begin
            vs[idx] <= sbs_pkg::sat32(q_s);
            if (idx == 2'd2) begin
              state <= ret;
            end else begin
              idx   <= idx + 2'd1;
              state <= S_SC_MUL;
            end
          end
        end

        S_SEEK_SC: begin
          ret   <= S_FORCE;
          state <= S_SCALE;
        end

        // Arrival: ramp = max_speed * distance / slowing_distance, capped at max_speed.
        S_ARR_MUL: begin
          if (slowing_distance == '0) begin
            mag   <= '0;
            ret   <= S_FORCE;
            state <= S_SCALE;
          end else begin
            state <= S_ARR_DIV;
          end
        end
        S_ARR_DIV: begin
          state <= S_ARR_WAIT;
        end
        S_ARR_WAIT: begin
          if (div_stat.done) begin
            mag   <= (div_quo > 64'(max_speed)) ? max_speed : div_quo[30:0];
            ret   <= S_FORCE;
            state <= S_SCALE;
          end
        end

        // Pursuit: unit target heading and unit direction away from the target.
        S_P_UA: begin
          ret   <= S_P_AWAY;
          state <= S_SCALE;
        end
        S_P_AWAY: begin
          for (int i = 0; i < 3; i++) begin
            ua[i] <= vs[i][sbs_pkg::UNIT_W-1:0];
            vw[i] <= sbs_pkg::sat_diff(own[i], tp[i]);
          end
          ret   <= S_P_UB;
          state <= S_LEN;
        end
        S_P_UB: begin
          ret   <= S_P_DOT0;
          state <= S_SCALE;
        end
        S_P_DOT0: begin
          idx   <= '0;
          dot   <= '0;
          state <= S_P_DOTM;
        end
        S_P_DOTM: begin
          state <= S_P_DOTA;
        end
        S_P_DOTA: begin
          dot <= dot + mul_p[sbs_pkg::DOT_W-1:0];
          if (idx == 2'd2) begin
            state <= S_P_PARA;
          end else begin
            idx   <= idx + 2'd1;
            state <= S_P_DOTM;
          end
        end
        S_P_PARA: begin
          // A target heading towards the agent gives a shorter prediction horizon.
          if (dq[65]) begin
            para <= sbs_pkg::UNIT_W'(sbs_pkg::ONE_Q);
          end else begin
            para <= sbs_pkg::UNIT_W'(sbs_pkg::wide_t'({35'b0, sbs_pkg::ONE_Q}) - dq);
          end
          for (int i = 0; i < 3; i++) begin
            vw[i] <= sbs_pkg::sat_diff(tp[i], own[i]);
          end
          ret   <= S_P_SPEED;
          state <= S_LEN;
        end
        S_P_SPEED: begin
          dist_len <= len_q;
          for (int i = 0; i < 3; i++) begin
            vw[i] <= vel[i];
          end
          ret   <= S_P_TU;
          state <= S_LEN;
        end
        S_P_TU: begin
          if (len_q == '0) begin
            t     <= '0;
            state <= S_P_PT0;
          end else begin
            state <= S_P_TUW;
          end
        end
        S_P_TUW: begin
          if (div_stat.done) begin
            tu    <= (div_quo > 64'h7FFFFFFF) ? 31'h7FFFFFFF : div_quo[30:0];
            state <= S_P_TM;
          end
        end
        S_P_TM: begin
          state <= S_P_TT;
        end
        S_P_TT: begin
          t     <= sbs_pkg::sat32(sbs_pkg::sdiv_pow2(mul_p));
          state <= S_P_PT0;
        end
        S_P_PT0: begin
          idx   <= '0;
          state <= S_P_PTM;
        end
        S_P_PTM: begin
          state <= S_P_PTA;
        end
        S_P_PTA: begin
          // Predicted point, kept in vs until the seek towards it.
          vs[idx] <= sbs_pkg::sat32(sbs_pkg::wide_t'(tp[idx]) +
                     sbs_pkg::wide_t'(sbs_pkg::sat32(sbs_pkg::sdiv_pow2(mul_p))));
          if (idx == 2'd2) begin
            state <= S_P_SEEK;
          end else begin
            idx   <= idx + 2'd1;
            state <= S_P_PTM;
          end
        end
        S_P_SEEK: begin
          for (int i = 0; i < 3; i++) begin
            vw[i] <= sbs_pkg::sat_diff(vs[i], own[i]);
          end
          mag   <= max_speed;
          ret   <= S_SEEK_SC;
          state <= S_LEN;
        end

        // Steering force = desired - velocity, negated for evade, then limited.
        S_FORCE: begin
          for (int i = 0; i < 3; i++) begin
            if (mode == sbs_pkg::MODE_EVADE) begin
              vw[i] <= sbs_pkg::sat32(-sbs_pkg::wide_t'(sbs_pkg::sat_diff(vs[i], vel[i])));
            end else begin
              vw[i] <= sbs_pkg::sat_diff(vs[i], vel[i]);
            end
          end
          ret   <= S_FCLAMP;
          state <= S_LEN;
        end
        S_FCLAMP: begin
          if (len_q > {1'b0, max_force}) begin
            mag   <= max_force;
            ret   <= S_ACC;
            state <= S_SCALE;
          end else begin
            for (int i = 0; i < 3; i++) begin
              vs[i] <= vw[i];
            end
            state <= S_ACC;
          end
        end

        // Acceleration = force / mass, added to the kept velocity; a zero mass leaves it as it is.
        S_ACC: begin
          idx <= '0;
          if (mass == '0) begin
            for (int i = 0; i < 3; i++) begin
              vw[i] <= vel[i];
            end
            ret   <= S_VCLAMP;
            state <= S_LEN;
          end else begin
            state <= S_ACC_DIV;
          end
        end
        S_ACC_DIV: begin
          state <= S_ACC_WAIT;
        end
        S_ACC_WAIT: begin
          if (div_stat.done) begin
            vw[idx] <= sbs_pkg::sat32(sbs_pkg::wide_t'(vel[idx]) +
                       sbs_pkg::wide_t'(sbs_pkg::sat32(q_s)));
            if (idx == 2'd2) begin
              ret   <= S_VCLAMP;
              state <= S_LEN;
            end else begin
              idx   <= idx + 2'd1;
              state <= S_ACC_DIV;
            end
          end
        end
        S_VCLAMP: begin
          if (len_q > {1'b0, max_speed}) begin
            mag   <= max_speed;
            ret   <= S_DONE;
            state <= S_SCALE;
          end else begin
            for (int i = 0; i < 3; i++) begin
              vs[i] <= vw[i];
            end
            state <= S_DONE;
          end
        end

        // Hand the word over once the output register is free.
        S_DONE: begin
          if (!out_valid || result.ready) begin
            for (int i = 0; i < 3; i++) begin
              vel[i]     <= vs[i];
              out_vel[i] <= vs[i];
              out_pos[i] <= sbs_pkg::sat32(sbs_pkg::wide_t'(own[i]) + sbs_pkg::wide_t'(vs[i]));
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The shared units are only started when idle.
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  a_sqrt_idle: assert property (@(posedge clk) disable iff (rst)
    sqrt_start |-> !sqrt_stat.busy)
    else $error("square root started while busy");

  // A result word appears only as the step completes.
  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result word raised outside completion");

endmodule
